// File: rtl/core/qrm_pkg.sv
// shared types and constants for the quadrilateral region mask
`timescale 1ns / 1ps

package qrm_pkg;

  // corner coordinates, signed q12.4
  localparam int CORNER_W = 16;
  // bounding box values in q.4, wide enough for the image size seed
  localparam int SPAN_W = 18;
  // floored bounds in whole pixels
  localparam int BOUND_W = SPAN_W - 4;

  localparam int COL_W = 10;
  localparam int ROW_W = 9;
  localparam int MASK_W = 8;
  localparam int CFG_IDX_W = 4;

  // register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_CORNER0_X = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CORNER0_Y = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CORNER1_X = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CORNER1_Y = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CORNER2_X = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CORNER2_Y = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_CORNER3_X = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_CORNER3_Y = 4'd7;
  localparam logic [CFG_IDX_W-1:0] REG_COUNT     = 4'd8;

  localparam logic [MASK_W-1:0] MASK_ON  = 8'd255;
  localparam logic [MASK_W-1:0] MASK_OFF = 8'd0;

  typedef struct packed {
    logic [COL_W-1:0] pixel_col;
    logic [ROW_W-1:0] pixel_row;
  } in_item_t;

  typedef struct packed {
    logic [MASK_W-1:0] mask_byte;
    logic              inside_flag;
  } out_item_t;

  // load enables of the three inner pipeline stages
  typedef struct packed {
    logic en1;
    logic en2;
    logic en3;
  } pipe_ctl_t;

endpackage

// File: rtl/core/qrm_span.sv
// bounding box span test on one axis, stages one and two
`timescale 1ns / 1ps

module qrm_span #(
  parameter int SIZE  = 640,
  parameter int PIX_W = 10
) (
  input  logic                                   clk,
  input  qrm_pkg::pipe_ctl_t                     ctl,
  input  logic signed [qrm_pkg::CORNER_W-1:0]    c0,
  input  logic signed [qrm_pkg::CORNER_W-1:0]    c1,
  input  logic signed [qrm_pkg::CORNER_W-1:0]    c2,
  input  logic signed [qrm_pkg::CORNER_W-1:0]    c3,
  input  logic        [PIX_W-1:0]                pix,
  output logic                                   in_span_r
);

  localparam logic signed [qrm_pkg::SPAN_W-1:0] SEED  = qrm_pkg::SPAN_W'(SIZE * 16);
  localparam logic signed [qrm_pkg::SPAN_W-1:0] LIMIT = qrm_pkg::SPAN_W'((SIZE - 1) * 16);

  logic signed [qrm_pkg::SPAN_W-1:0]  pts [4];
  logic signed [qrm_pkg::SPAN_W-1:0]  hi;
  logic signed [qrm_pkg::SPAN_W-1:0]  lo;
  logic        [qrm_pkg::BOUND_W-1:0] lo_f_nxt;
  logic        [qrm_pkg::BOUND_W-1:0] hi_f_nxt;
  logic        [qrm_pkg::BOUND_W-1:0] lo_f_r;
  logic        [qrm_pkg::BOUND_W-1:0] hi_f_r;
  logic        [qrm_pkg::BOUND_W-1:0] pix_r;
  logic                               in_span_nxt;

  always_comb begin
    pts[0] = qrm_pkg::SPAN_W'(c0);
    pts[1] = qrm_pkg::SPAN_W'(c1);
    pts[2] = qrm_pkg::SPAN_W'(c2);
    pts[3] = qrm_pkg::SPAN_W'(c3);
    hi = '0;
    lo = SEED;
    for (int k = 0; k < 4; k++) begin
      if (pts[k] > hi) hi = pts[k];
      if (pts[k] < lo) lo = pts[k];
    end
    if (hi >= SEED) hi = LIMIT;
    if (lo < 0) lo = '0;
    // both bounds are nonnegative here, so floor is a plain shift
    lo_f_nxt = lo[qrm_pkg::SPAN_W-1:4];
    hi_f_nxt = hi[qrm_pkg::SPAN_W-1:4];
  end

  assign in_span_nxt = (pix_r >= lo_f_r) && (pix_r <= hi_f_r);

  always_ff @(posedge clk) begin
    if (ctl.en1) begin
      lo_f_r <= lo_f_nxt;
      hi_f_r <= hi_f_nxt;
      pix_r  <= qrm_pkg::BOUND_W'(pix);
    end
    if (ctl.en2) begin
      in_span_r <= in_span_nxt;
    end
  end

endmodule

// File: rtl/core/qrm_edge.sv
// three stage edge function evaluation for the line through two corners
`timescale 1ns / 1ps

module qrm_edge (
  input  logic                                clk,
  input  qrm_pkg::pipe_ctl_t                  ctl,
  input  logic signed [qrm_pkg::CORNER_W-1:0] px,
  input  logic signed [qrm_pkg::CORNER_W-1:0] py,
  input  logic signed [qrm_pkg::CORNER_W-1:0] qx,
  input  logic signed [qrm_pkg::CORNER_W-1:0] qy,
  input  logic        [qrm_pkg::COL_W-1:0]    col,
  input  logic        [qrm_pkg::ROW_W-1:0]    row,
  output logic                                pos_r,
  output logic                                neg_r
);

  localparam int DIFF_W = qrm_pkg::CORNER_W + 1;
  localparam int AX_W   = DIFF_W + qrm_pkg::COL_W + 1;
  localparam int BY_W   = DIFF_W + qrm_pkg::ROW_W + 1;
  localparam int PROD_W = 2 * qrm_pkg::CORNER_W;
  localparam int LIN_W  = AX_W + 1;
  localparam int C_W    = PROD_W + 1;
  localparam int VAL_W  = C_W + 1;

  logic signed [DIFF_W-1:0] a;
  logic signed [DIFF_W-1:0] b;
  logic signed [qrm_pkg::COL_W:0] xs;
  logic signed [qrm_pkg::ROW_W:0] ys;

  logic signed [AX_W-1:0]   ax_nxt, ax_r;
  logic signed [BY_W-1:0]   by_nxt, by_r;
  logic signed [PROD_W-1:0] c1_nxt, c1_r;
  logic signed [PROD_W-1:0] c2_nxt, c2_r;
  logic signed [LIN_W-1:0]  lin_nxt, lin_r;
  logic signed [C_W-1:0]    cc_nxt, cc_r;
  logic signed [VAL_W-1:0]  val;

  always_comb begin
    a  = DIFF_W'(qy) - DIFF_W'(py);
    b  = DIFF_W'(px) - DIFF_W'(qx);
    xs = $signed({1'b0, col});
    ys = $signed({1'b0, row});
    ax_nxt = AX_W'(a) * AX_W'(xs);
    by_nxt = BY_W'(b) * BY_W'(ys);
    c1_nxt = PROD_W'(py) * PROD_W'(qx);
    c2_nxt = PROD_W'(qy) * PROD_W'(px);
    lin_nxt = LIN_W'(ax_r) + LIN_W'(by_r);
    cc_nxt  = C_W'(c1_r) - C_W'(c2_r);
    // line value in q.8: (a*x + b*y) * 16 + c
    val = (VAL_W'(lin_r) <<< 4) + VAL_W'(cc_r);
  end

  always_ff @(posedge clk) begin
    if (ctl.en1) begin
      ax_r <= ax_nxt;
      by_r <= by_nxt;
      c1_r <= c1_nxt;
      c2_r <= c2_nxt;
    end
    if (ctl.en2) begin
      lin_r <= lin_nxt;
      cc_r  <= cc_nxt;
    end
    if (ctl.en3) begin
      pos_r <= (val > 0);
      neg_r <= (val < 0);
    end
  end

endmodule

// File: rtl/core/quad_region_mask.sv
// top level of the quadrilateral region mask pipeline
// throughput: one pixel per cycle while out_stall is low, through the four stage pipeline
// (multiply, partial sums, edge value and sign, mask output register)
// each stage holds its item while the next one is full and stalled
// rst_n (synchronous) clears all stage valids and sets every corner to zero
`timescale 1ns / 1ps

module quad_region_mask #(
  parameter int IMAGE_WIDTH  = 640,
  parameter int IMAGE_HEIGHT = 480
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  qrm_pkg::in_item_t                 in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output qrm_pkg::out_item_t                out_data,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [qrm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [qrm_pkg::CORNER_W-1:0]      cfg_data
);

  logic signed [qrm_pkg::CORNER_W-1:0] corner_r [8];

  logic v1_r, v2_r, v3_r, vo_r;
  logic rdy1, rdy2, rdy3, rdy_o;
  qrm_pkg::pipe_ctl_t ctl;

  logic col_span, row_span;
  logic box3_r;
  logic [3:0] pos, neg;
  logic inside_nxt;
  qrm_pkg::out_item_t out_nxt, out_r;

  // corner registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < 8; k++) corner_r[k] <= '0;
    end else if (cfg_valid && (cfg_index < qrm_pkg::REG_COUNT)) begin
      corner_r[cfg_index[2:0]] <= cfg_data;
    end
  end

  assign cfg_ready = 1'b1;

  // per stage ready chain
  assign rdy_o   = !vo_r || !out_stall;
  assign rdy3    = !v3_r || rdy_o;
  assign rdy2    = !v2_r || rdy3;
  assign rdy1    = !v1_r || rdy2;
  assign in_stall = !rdy1;
  assign ctl.en1 = rdy1;
  assign ctl.en2 = rdy2;
  assign ctl.en3 = rdy3;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      vo_r <= 1'b0;
    end else begin
      if (rdy1)  v1_r <= in_valid;
      if (rdy2)  v2_r <= v1_r;
      if (rdy3)  v3_r <= v2_r;
      if (rdy_o) vo_r <= v3_r;
    end
  end

  qrm_span #(.SIZE(IMAGE_WIDTH), .PIX_W(qrm_pkg::COL_W)) u_span_col (
    .clk       (clk),
    .ctl       (ctl),
    .c0        (corner_r[qrm_pkg::REG_CORNER0_X[2:0]]),
    .c1        (corner_r[qrm_pkg::REG_CORNER1_X[2:0]]),
    .c2        (corner_r[qrm_pkg::REG_CORNER2_X[2:0]]),
    .c3        (corner_r[qrm_pkg::REG_CORNER3_X[2:0]]),
    .pix       (in_data.pixel_col),
    .in_span_r (col_span)
  );

  qrm_span #(.SIZE(IMAGE_HEIGHT), .PIX_W(qrm_pkg::ROW_W)) u_span_row (
    .clk       (clk),
    .ctl       (ctl),
    .c0        (corner_r[qrm_pkg::REG_CORNER0_Y[2:0]]),
    .c1        (corner_r[qrm_pkg::REG_CORNER1_Y[2:0]]),
    .c2        (corner_r[qrm_pkg::REG_CORNER2_Y[2:0]]),
    .c3        (corner_r[qrm_pkg::REG_CORNER3_Y[2:0]]),
    .pix       (in_data.pixel_row),
    .in_span_r (row_span)
  );

  // edge 0-3
  qrm_edge u_edge0 (
    .clk (clk), .ctl (ctl),
    .px  (corner_r[qrm_pkg::REG_CORNER0_X[2:0]]), .py (corner_r[qrm_pkg::REG_CORNER0_Y[2:0]]),
    .qx  (corner_r[qrm_pkg::REG_CORNER3_X[2:0]]), .qy (corner_r[qrm_pkg::REG_CORNER3_Y[2:0]]),
    .col (in_data.pixel_col), .row (in_data.pixel_row),
    .pos_r (pos[0]), .neg_r (neg[0])
  );

  // edge 1-2
  qrm_edge u_edge1 (
    .clk (clk), .ctl (ctl),
    .px  (corner_r[qrm_pkg::REG_CORNER1_X[2:0]]), .py (corner_r[qrm_pkg::REG_CORNER1_Y[2:0]]),
    .qx  (corner_r[qrm_pkg::REG_CORNER2_X[2:0]]), .qy (corner_r[qrm_pkg::REG_CORNER2_Y[2:0]]),
    .col (in_data.pixel_col), .row (in_data.pixel_row),
    .pos_r (pos[1]), .neg_r (neg[1])
  );

  // edge 0-1
  qrm_edge u_edge2 (
    .clk (clk), .ctl (ctl),
    .px  (corner_r[qrm_pkg::REG_CORNER0_X[2:0]]), .py (corner_r[qrm_pkg::REG_CORNER0_Y[2:0]]),
    .qx  (corner_r[qrm_pkg::REG_CORNER1_X[2:0]]), .qy (corner_r[qrm_pkg::REG_CORNER1_Y[2:0]]),
    .col (in_data.pixel_col), .row (in_data.pixel_row),
    .pos_r (pos[2]), .neg_r (neg[2])
  );

  // edge 3-2
  qrm_edge u_edge3 (
    .clk (clk), .ctl (ctl),
    .px  (corner_r[qrm_pkg::REG_CORNER3_X[2:0]]), .py (corner_r[qrm_pkg::REG_CORNER3_Y[2:0]]),
    .qx  (corner_r[qrm_pkg::REG_CORNER2_X[2:0]]), .qy (corner_r[qrm_pkg::REG_CORNER2_Y[2:0]]),
    .col (in_data.pixel_col), .row (in_data.pixel_row),
    .pos_r (pos[3]), .neg_r (neg[3])
  );

  // inside needs the box test; opposite edges pass unless both strictly on the same side
  always_comb begin
    inside_nxt = box3_r
              && !((pos[0] && pos[1]) || (neg[0] && neg[1]))
              && !((pos[2] && pos[3]) || (neg[2] && neg[3]));
    out_nxt.inside_flag = inside_nxt;
    out_nxt.mask_byte   = inside_nxt ? qrm_pkg::MASK_ON : qrm_pkg::MASK_OFF;
  end

  always_ff @(posedge clk) begin
    if (rdy3)  box3_r <= col_span && row_span;
    if (rdy_o) out_r  <= out_nxt;
  end

  assign out_valid = vo_r;
  assign out_data  = out_r;

endmodule

// File: rtl/core/qrm_checker.sv
// port level checker for the quadrilateral region mask, bound to the top level
`timescale 1ns / 1ps

module qrm_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic                          out_valid,
  input logic                          out_stall,
  input qrm_pkg::out_item_t            out_data,
  input logic                          cfg_valid,
  input logic                          cfg_ready
);

  // a stalled result stays and holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // mask byte and flag agree
  a_mask_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.mask_byte ==
                   (out_data.inside_flag ? qrm_pkg::MASK_ON : qrm_pkg::MASK_OFF)))
    else $error("mask byte does not match inside flag");

  // with the output stage empty the pipeline cannot be backed up
  a_no_stall_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !in_stall)
    else $error("input stalled with empty output stage");

  // an input transfer with a free pipeline reaches the output if the output is not stalled in between
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && !out_valid ##1 !out_stall ##1 !out_stall ##1 !out_stall
    |=> out_valid)
    else $error("result missing after pipeline latency");

  // the configuration port never back-pressures
  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid |-> cfg_ready)
    else $error("configuration write not taken");

endmodule

bind quad_region_mask qrm_checker u_qrm_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data),
  .cfg_valid (cfg_valid),
  .cfg_ready (cfg_ready)
);

// File: sim/tb_quad_region_mask.sv
// self-checking testbench for the quadrilateral region mask pipeline
`timescale 1ns / 1ps

module tb_quad_region_mask;

  localparam int IMG_W = 640;
  localparam int IMG_H = 480;
  localparam int LATENCY = 4;
  localparam int CYCLE_LIMIT = 200000;
  localparam int SHAPES_PER_PHASE = 6;
  localparam int ITEMS_PER_SHAPE = 28;

  typedef logic [int'(qrm_pkg::REG_COUNT)-1:0][qrm_pkg::CORNER_W-1:0] quad_t;

  typedef struct {
    qrm_pkg::in_item_t  pixel;
    qrm_pkg::out_item_t want;
  } pending_mask_t;

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  qrm_pkg::in_item_t in_data;
  logic out_valid;
  logic out_stall;
  qrm_pkg::out_item_t out_data;
  logic cfg_valid;
  logic cfg_ready;
  logic [qrm_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [qrm_pkg::CORNER_W-1:0] cfg_data;

  quad_t corner_cfg;
  pending_mask_t masks_pending[$];
  int mismatch_count = 0;
  int cycle_count = 0;
  int sender_idle_pct = 0;
  int sink_stall_pct = 0;

  quad_region_mask #(
    .IMAGE_WIDTH (IMG_W),
    .IMAGE_HEIGHT(IMG_H)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------- predictor

  // axis 0 is x, axis 1 is y; value in q.4
  function automatic longint corner_at(input int axis, input int k);
    return longint'($signed(corner_cfg[k * 2 + axis]));
  endfunction

  // line through corners p and q at integer pixel (x, y), in q.8
  function automatic longint line_value(input int p, input int q, input longint x,
                                        input longint y);
    longint a, b, c;
    a = corner_at(1, q) - corner_at(1, p);
    b = corner_at(0, p) - corner_at(0, q);
    c = corner_at(1, p) * corner_at(0, q) - corner_at(1, q) * corner_at(0, p);
    return (a * x + b * y) * 16 + c;
  endfunction

  function automatic bit opposite_sides(input longint u, input longint v);
    return (u == 0) || (v == 0) || ((u < 0) != (v < 0));
  endfunction

  // box seeded with max 0 and min at the image size, clamped, then floored
  function automatic bit in_box(input int axis, input longint size, input longint p);
    longint span_lo, span_hi, c;
    span_hi = 0;
    span_lo = size * 16;
    for (int k = 0; k < 4; k++) begin
      c = corner_at(axis, k);
      if (c > span_hi) span_hi = c;
      if (c < span_lo) span_lo = c;
    end
    if (span_hi >= size * 16) span_hi = (size - 1) * 16;
    if (span_lo < 0) span_lo = 0;
    return (p >= span_lo / 16) && (p <= span_hi / 16);
  endfunction

  function automatic qrm_pkg::out_item_t predict_mask(input qrm_pkg::in_item_t px);
    longint x, y;
    bit hit;
    qrm_pkg::out_item_t r;
    x = longint'(px.pixel_col);
    y = longint'(px.pixel_row);
    hit = in_box(0, IMG_W, x) && in_box(1, IMG_H, y);
    if (hit) begin
      hit = opposite_sides(line_value(0, 3, x, y), line_value(1, 2, x, y)) &&
            opposite_sides(line_value(0, 1, x, y), line_value(3, 2, x, y));
    end
    r.mask_byte = hit ? qrm_pkg::MASK_ON : qrm_pkg::MASK_OFF;
    r.inside_flag = hit;
    return r;
  endfunction

  // ---------------------------------------------------------------- helpers

  function automatic quad_t make_quad(input int x0, input int y0, input int x1, input int y1,
                                      input int x2, input int y2, input int x3, input int y3);
    quad_t q;
    q[qrm_pkg::REG_CORNER0_X] = x0[qrm_pkg::CORNER_W-1:0];
    q[qrm_pkg::REG_CORNER0_Y] = y0[qrm_pkg::CORNER_W-1:0];
    q[qrm_pkg::REG_CORNER1_X] = x1[qrm_pkg::CORNER_W-1:0];
    q[qrm_pkg::REG_CORNER1_Y] = y1[qrm_pkg::CORNER_W-1:0];
    q[qrm_pkg::REG_CORNER2_X] = x2[qrm_pkg::CORNER_W-1:0];
    q[qrm_pkg::REG_CORNER2_Y] = y2[qrm_pkg::CORNER_W-1:0];
    q[qrm_pkg::REG_CORNER3_X] = x3[qrm_pkg::CORNER_W-1:0];
    q[qrm_pkg::REG_CORNER3_Y] = y3[qrm_pkg::CORNER_W-1:0];
    return q;
  endfunction

  function automatic int jitter(input int span);
    return int'($urandom_range(2 * span)) - span;
  endfunction

  function automatic int clamp_int(input int v, input int lo, input int hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  // leaves cfg_valid high; the caller lowers it after the last write
  task automatic write_reg(input int idx, input logic [qrm_pkg::CORNER_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx[qrm_pkg::CFG_IDX_W-1:0];
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx < int'(qrm_pkg::REG_COUNT)) corner_cfg[idx] = value;
  endtask

  task automatic load_corners(input quad_t q);
    for (int i = qrm_pkg::REG_CORNER0_X; i <= qrm_pkg::REG_CORNER3_Y; i++) write_reg(i, q[i]);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_pixel(input int col, input int row);
    qrm_pkg::in_item_t px;
    pending_mask_t entry;
    px.pixel_col = col[qrm_pkg::COL_W-1:0];
    px.pixel_row = row[qrm_pkg::ROW_W-1:0];
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= px;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    entry.pixel = px;
    entry.want = predict_mask(px);
    masks_pending.insert(masks_pending.size(), entry);
  endtask

  task automatic drain_masks();
    in_valid <= 1'b0;
    while (masks_pending.size() != 0) @(posedge clk);
    repeat (LATENCY + 2) @(posedge clk);
  endtask

  // ---------------------------------------------------------------- tests

  // all corners at zero after reset: only pixel (0, 0) is in the box
  task automatic test_reset_corners();
    send_pixel(0, 0);
    send_pixel(1, 0);
    send_pixel(0, 1);
    drain_masks();
  endtask

  task automatic test_square_and_diamond();
    load_corners(make_quad(100 * 16, 100 * 16, 300 * 16, 100 * 16,
                           300 * 16, 250 * 16, 100 * 16, 250 * 16));
    send_pixel(200, 175);
    send_pixel(100, 100);
    send_pixel(300, 250);
    send_pixel(99, 175);
    send_pixel(200, 251);
    drain_masks();
    // fractional corners, slanted edges
    load_corners(make_quad(5128, 1600, 6720, 3844, 5120, 6080, 3520, 3840));
    send_pixel(320, 240);
    send_pixel(250, 130);
    send_pixel(420, 240);
    drain_masks();
  endtask

  // corners at the register extremes, box clamped to the whole image
  task automatic test_image_limits();
    load_corners(make_quad(-32768, -32768, 32767, -32768, 32767, 32767, -32768, 32767));
    send_pixel(0, 0);
    send_pixel(IMG_W - 1, IMG_H - 1);
    send_pixel(IMG_W, 0);
    send_pixel(0, IMG_H);
    send_pixel((1 << qrm_pkg::COL_W) - 1, (1 << qrm_pkg::ROW_W) - 1);
    drain_masks();
  endtask

  task automatic test_offscreen_corners();
    // all left of and above the image: max stays at its zero seed
    load_corners(make_quad(-16, -32, -1600, -80, -8, -3000, -32768, -1));
    send_pixel(0, 0);
    send_pixel(1, 1);
    drain_masks();
    // all right of and below the image: empty box
    load_corners(make_quad(IMG_W * 16, IMG_H * 16, 32767, 500 * 16,
                           700 * 16, 32767, IMG_W * 16 + 5, IMG_H * 16 + 1));
    send_pixel(IMG_W - 1, IMG_H - 1);
    send_pixel(0, 0);
    drain_masks();
  endtask

  task automatic test_coincident_corners();
    load_corners(make_quad(808, 964, 808, 964, 808, 964, 808, 964));
    send_pixel(50, 60);
    send_pixel(51, 60);
    drain_masks();
  endtask

  // writes past the last corner must leave the corners alone
  task automatic test_unused_index();
    for (int i = qrm_pkg::REG_COUNT; i < (1 << qrm_pkg::CFG_IDX_W); i++) begin
      write_reg(i, qrm_pkg::CORNER_W'($urandom_range((1 << qrm_pkg::CORNER_W) - 1)));
    end
    cfg_valid <= 1'b0;
    send_pixel(50, 60);
    send_pixel(51, 60);
    drain_masks();
  endtask

  task automatic test_random_quads(input int idle_pct, input int stall_pct);
    quad_t q;
    int mode, ctr_x, ctr_y, half_w, half_h, other_x, other_y;
    int cx_q4, cy_q4, col_lo, col_hi, row_lo, row_hi, pick, col, row;
    sender_idle_pct = idle_pct;
    sink_stall_pct = stall_pct;
    for (int s = 0; s < SHAPES_PER_PHASE; s++) begin
      mode = $urandom_range(99);
      ctr_x = $urandom_range(IMG_W - 1);
      ctr_y = $urandom_range(IMG_H - 1);
      half_w = 4 + $urandom_range(200);
      half_h = 4 + $urandom_range(160);
      other_x = 16 * $urandom_range(IMG_W - 1) + $urandom_range(15);
      other_y = 16 * $urandom_range(IMG_H - 1) + $urandom_range(15);
      for (int k = 0; k < 4; k++) begin
        if (mode < 65) begin
          // corners go round the center: top left, top right, bottom right, bottom left
          cx_q4 = 16 * (ctr_x + ((k == 1 || k == 2) ? half_w : -half_w) + jitter(half_w / 2))
                  + $urandom_range(15);
          cy_q4 = 16 * (ctr_y + ((k >= 2) ? half_h : -half_h) + jitter(half_h / 2))
                  + $urandom_range(15);
        end else if (mode < 80) begin
          cx_q4 = 16 * (int'($urandom_range(IMG_W + 100)) - 50) + $urandom_range(15);
          cy_q4 = 16 * (int'($urandom_range(IMG_H + 100)) - 50) + $urandom_range(15);
        end else if (mode < 90) begin
          cx_q4 = $urandom_range((1 << qrm_pkg::CORNER_W) - 1);
          cy_q4 = $urandom_range((1 << qrm_pkg::CORNER_W) - 1);
        end else begin
          // coincident corners, all four or two pairs
          cx_q4 = (mode < 95 || k < 2) ? 16 * ctr_x + 5 : other_x;
          cy_q4 = (mode < 95 || k < 2) ? 16 * ctr_y + 9 : other_y;
        end
        q[2 * k] = cx_q4[qrm_pkg::CORNER_W-1:0];
        q[2 * k + 1] = cy_q4[qrm_pkg::CORNER_W-1:0];
      end
      load_corners(q);

      // pixel range around the corners, to land near the edges often
      col_lo = 1 << 30;
      col_hi = -(1 << 30);
      row_lo = 1 << 30;
      row_hi = -(1 << 30);
      for (int k = 0; k < 4; k++) begin
        cx_q4 = $signed(q[2 * k]) >>> 4;
        cy_q4 = $signed(q[2 * k + 1]) >>> 4;
        if (cx_q4 < col_lo) col_lo = cx_q4;
        if (cx_q4 > col_hi) col_hi = cx_q4;
        if (cy_q4 < row_lo) row_lo = cy_q4;
        if (cy_q4 > row_hi) row_hi = cy_q4;
      end
      col_lo = clamp_int(col_lo - 2, 0, IMG_W - 1);
      col_hi = clamp_int(col_hi + 2, 0, IMG_W - 1);
      row_lo = clamp_int(row_lo - 2, 0, IMG_H - 1);
      row_hi = clamp_int(row_hi + 2, 0, IMG_H - 1);

      for (int n = 0; n < ITEMS_PER_SHAPE; n++) begin
        pick = $urandom_range(99);
        if (pick < 75) begin
          col = $urandom_range(col_hi, col_lo);
          row = $urandom_range(row_hi, row_lo);
        end else if (pick < 90) begin
          col = $urandom_range(IMG_W - 1);
          row = $urandom_range(IMG_H - 1);
        end else begin
          col = $urandom_range((1 << qrm_pkg::COL_W) - 1);
          row = $urandom_range((1 << qrm_pkg::ROW_W) - 1);
        end
        send_pixel(col, row);
      end
      drain_masks();
    end
  endtask

  // ---------------------------------------------------------------- checking

  always @(posedge clk) begin
    out_stall <= rst_n && ($urandom_range(99) < sink_stall_pct);
  end

  always @(posedge clk) begin : check_masks
    pending_mask_t due;
    if (rst_n && out_valid && !out_stall) begin
      if (masks_pending.size() == 0) begin
        report_mismatch($sformatf("mask transfer with no pixel pending: mask %0d flag %0b",
                                  out_data.mask_byte, out_data.inside_flag));
      end else begin
        due = masks_pending.pop_front();
        if (out_data.mask_byte !== due.want.mask_byte) begin
          report_mismatch($sformatf("mask_byte col %0d row %0d: got %0d want %0d",
                                    due.pixel.pixel_col, due.pixel.pixel_row,
                                    out_data.mask_byte, due.want.mask_byte));
        end
        if (out_data.inside_flag !== due.want.inside_flag) begin
          report_mismatch($sformatf("inside_flag col %0d row %0d: got %0b want %0b",
                                    due.pixel.pixel_col, due.pixel.pixel_row,
                                    out_data.inside_flag, due.want.inside_flag));
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d masks pending", cycle_count,
               masks_pending.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  // ---------------------------------------------------------------- sequence

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    corner_cfg = '0;
    sender_idle_pct = 28;
    sink_stall_pct = 49;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_corners();
    test_square_and_diamond();
    test_image_limits();
    test_offscreen_corners();
    test_coincident_corners();
    test_unused_index();
    test_random_quads(28, 49);
    test_random_quads(49, 28);
    test_random_quads(0, 0);

    drain_masks();
    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/core/qrm_pkg.sv
rtl/core/qrm_span.sv
rtl/core/qrm_edge.sv
rtl/core/quad_region_mask.sv
rtl/core/qrm_checker.sv
sim/tb_quad_region_mask.sv
